// ===== sv/ffpa_pkg.sv =====
// shared types and constants for the first-fit partition allocator
package ffpa_pkg;

   localparam int TOTAL_UNITS  = 512;
   localparam int MAX_SEGMENTS = 64;

   localparam int ADDR_W  = 9;
   localparam int LEN_W   = 10;
   localparam int OWNER_W = 8;
   localparam int IDX_W   = $clog2(MAX_SEGMENTS);
   localparam int CNT_W   = $clog2(MAX_SEGMENTS + 1);
   localparam int STAT_W  = 3;

   localparam logic OP_ALLOC   = 1'b0;
   localparam logic OP_RELEASE = 1'b1;

   localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
   localparam logic [STAT_W-1:0] ST_NO_SPACE  = 3'd1;
   localparam logic [STAT_W-1:0] ST_NO_OWNER  = 3'd2;
   localparam logic [STAT_W-1:0] ST_EXCEEDS   = 3'd3;
   localparam logic [STAT_W-1:0] ST_TABLE_FULL = 3'd4;

   typedef struct packed {
      logic                 alloc;
      logic [OWNER_W-1:0]   owner;
      logic [LEN_W-1:0]     len;
      logic [ADDR_W-1:0]    start;
   } entry_type;

   localparam entry_type RESET_ENTRY = '{alloc: 1'b0, owner: '0,
                                         len: LEN_W'(TOTAL_UNITS), start: '0};

   typedef enum logic [1:0] {
      SH_NONE,
      SH_RIGHT,
      SH_LEFT1,
      SH_LEFT2
   } shift_type;

   // search request seen by every cell
   typedef struct packed {
      logic               op;
      logic [OWNER_W-1:0] owner;
      logic [LEN_W-1:0]   amount;
      logic [CNT_W-1:0]   count;
   } query_type;

   // update broadcast to every cell
   typedef struct packed {
      logic             apply;
      logic             we_lo;
      logic             we_hi;
      logic [CNT_W-1:0] lo_idx;
      entry_type        data_lo;
      entry_type        data_hi;
      shift_type        shift;
      logic [CNT_W-1:0] base;
   } cmd_type;

endpackage

// ===== sv/ffpa_cell.sv =====
// one segment table cell: holds an entry, matches the query, shifts with its neighbors
module ffpa_cell #(
   parameter int IDX = 0
) (
   input  logic                clock,
   input  logic                reset,
   input  ffpa_pkg::query_type qry,
   input  ffpa_pkg::cmd_type   cmd,
   input  ffpa_pkg::entry_type lower_in,
   input  ffpa_pkg::entry_type upper1_in,
   input  ffpa_pkg::entry_type upper2_in,
   output ffpa_pkg::entry_type entry,
   output logic                match
);
   import ffpa_pkg::*;

   localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(IDX);

   entry_type entry_ff;
   entry_type entry_in;
   logic      valid;

   assign valid = MY_IDX < qry.count;

   always_comb begin
      if (qry.op == OP_ALLOC) begin
         match = valid && !entry_ff.alloc && (entry_ff.len >= qry.amount);
      end else begin
         match = valid && entry_ff.alloc && (entry_ff.owner == qry.owner);
      end
   end

   always_comb begin
      entry_in = entry_ff;
      if (cmd.apply) begin
         if (cmd.we_lo && (cmd.lo_idx == MY_IDX)) begin
            entry_in = cmd.data_lo;
         end else if (cmd.we_hi && (cmd.lo_idx + CNT_W'(1) == MY_IDX)) begin
            entry_in = cmd.data_hi;
         end else if (MY_IDX >= cmd.base) begin
            case (cmd.shift)
               SH_RIGHT: entry_in = lower_in;
               SH_LEFT1: entry_in = upper1_in;
               SH_LEFT2: entry_in = upper2_in;
               default:  entry_in = entry_ff;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff <= (IDX == 0) ? RESET_ENTRY : '0;
      end else begin
         entry_ff <= entry_in;
      end
   end

   assign entry = entry_ff;

endmodule

// ===== sv/first_fit_partition_allocator_top.sv =====
// first-fit partition allocator top level: request control and the row of segment cells
//
//  channel | dir | tdata fields (low bit up)                       | tuser
//  req_    | in  | owner[7:0], amount[17:8], zero pad to 24        | operation
//  rsp_    | out | status[2:0], seg_start[11:3], seg_count[18:12]  | -
//
// a request passes through accept, search the cells for the first fit or
// owner, gather the chosen segment and its neighbors, decide and update
// the cells shift or merge in the cycle after the decision, overlapping the next accept
// reset puts one free segment over the whole memory in cell 0
// a result waiting in the output register stalls only the decide step
module first_fit_partition_allocator_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // owner[7:0], amount[17:8]
   input  logic        req_tuser,   // operation
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata    // status[2:0], seg_start[11:3], seg_count[18:12]
);
   import ffpa_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE,
      S_FIND,
      S_GATHER,
      S_DECIDE
   } state_type;

   state_type           state_ff;
   logic                op_ff;
   logic [OWNER_W-1:0]  owner_ff;
   logic [LEN_W-1:0]    amount_ff;
   logic [CNT_W-1:0]    count_ff;
   logic [CNT_W-1:0]    count_in;

   logic [MAX_SEGMENTS-1:0] match;
   logic [MAX_SEGMENTS-1:0] first_ff;
   logic                    any_ff;
   logic [IDX_W-1:0]        pos_ff;
   entry_type               sel_ff, prev_ff, next_ff;

   entry_type cells [MAX_SEGMENTS];
   query_type qry;
   cmd_type   cmd_ff, cmd_in;

   logic                rsp_valid_ff;
   logic [STAT_W-1:0]   rsp_status_ff, status_in;
   logic [ADDR_W-1:0]   rsp_start_ff, start_in;
   logic [CNT_W-1:0]    rsp_count_ff;
   logic                out_free;

   assign req_tready = (state_ff == S_IDLE);
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign qry        = '{op: op_ff, owner: owner_ff, amount: amount_ff, count: count_ff};

   // the row of cells, each wired to its neighbors
   for (genvar k = 0; k < MAX_SEGMENTS; k++) begin : g_cell
      entry_type lower_e, upper1_e, upper2_e;
      if (k > 0) begin : g_lo
         assign lower_e = cells[k-1];
      end else begin : g_lo0
         assign lower_e = '0;
      end
      if (k + 1 < MAX_SEGMENTS) begin : g_u1
         assign upper1_e = cells[k+1];
      end else begin : g_u10
         assign upper1_e = '0;
      end
      if (k + 2 < MAX_SEGMENTS) begin : g_u2
         assign upper2_e = cells[k+2];
      end else begin : g_u20
         assign upper2_e = '0;
      end
      ffpa_cell #(.IDX(k)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .qry       (qry),
         .cmd       (cmd_ff),
         .lower_in  (lower_e),
         .upper1_in (upper1_e),
         .upper2_in (upper2_e),
         .entry     (cells[k]),
         .match     (match[k])
      );
   end

   // first matching cell as a one-hot mask and its index
   logic [MAX_SEGMENTS-1:0] first_c;
   logic [IDX_W-1:0]        pos_c;
   always_comb begin
      first_c = match & (~match + MAX_SEGMENTS'(1));
      pos_c   = '0;
      for (int k = 0; k < MAX_SEGMENTS; k++) begin
         if (first_c[k]) pos_c = pos_c | IDX_W'(k);
      end
   end

   // chosen segment and its neighbors by one-hot select
   entry_type sel_c, prev_c, next_c;
   always_comb begin
      sel_c  = '0;
      prev_c = '0;
      next_c = '0;
      for (int k = 0; k < MAX_SEGMENTS; k++) begin
         if (first_ff[k]) sel_c = sel_c | cells[k];
         if (k + 1 < MAX_SEGMENTS && first_ff[(k+1) % MAX_SEGMENTS]) begin
            prev_c = prev_c | cells[k];
         end
         if (k > 0 && first_ff[(k+MAX_SEGMENTS-1) % MAX_SEGMENTS]) begin
            next_c = next_c | cells[k];
         end
      end
   end

   // decision: status, result start and the cell update
   always_comb begin
      logic [CNT_W-1:0]  pc;
      logic              prev_free, next_free, table_full;
      logic [ADDR_W-1:0] rest_start;
      logic [LEN_W-1:0]  rest_len;
      pc         = CNT_W'(pos_ff);
      prev_free  = (pos_ff != '0) && !prev_ff.alloc;
      next_free  = (pc + CNT_W'(1) < count_ff) && !next_ff.alloc;
      table_full = (count_ff == CNT_W'(MAX_SEGMENTS));
      rest_start = ADDR_W'(LEN_W'(sel_ff.start) + amount_ff);
      rest_len   = sel_ff.len - amount_ff;
      cmd_in     = '0;
      cmd_in.shift = SH_NONE;
      count_in   = count_ff;
      status_in  = ST_OK;
      start_in   = sel_ff.start;
      if (op_ff == OP_ALLOC) begin
         if (amount_ff == '0 || !any_ff) begin
            status_in = ST_NO_SPACE;
         end else if (sel_ff.len == amount_ff) begin
            cmd_in.we_lo   = 1'b1;
            cmd_in.lo_idx  = pc;
            cmd_in.data_lo = '{alloc: 1'b1, owner: owner_ff, len: amount_ff,
                               start: sel_ff.start};
         end else if (table_full) begin
            status_in = ST_TABLE_FULL;
         end else begin
            // split: allocated head, free remainder behind it
            cmd_in.we_lo   = 1'b1;
            cmd_in.we_hi   = 1'b1;
            cmd_in.lo_idx  = pc;
            cmd_in.data_lo = '{alloc: 1'b1, owner: owner_ff, len: amount_ff,
                               start: sel_ff.start};
            cmd_in.data_hi = '{alloc: 1'b0, owner: '0, len: rest_len, start: rest_start};
            cmd_in.shift   = SH_RIGHT;
            cmd_in.base    = pc + CNT_W'(2);
            count_in       = count_ff + CNT_W'(1);
         end
      end else begin
         if (!any_ff) begin
            status_in = ST_NO_OWNER;
         end else if (amount_ff == '0 || amount_ff > sel_ff.len) begin
            status_in = ST_EXCEEDS;
         end else if (amount_ff == sel_ff.len) begin
            // whole release, coalesce on both sides
            cmd_in.we_lo = 1'b1;
            if (prev_free && next_free) begin
               cmd_in.lo_idx  = pc - CNT_W'(1);
               cmd_in.data_lo = '{alloc: 1'b0, owner: '0,
                                  len: prev_ff.len + sel_ff.len + next_ff.len,
                                  start: prev_ff.start};
               cmd_in.shift   = SH_LEFT2;
               cmd_in.base    = pc;
               count_in       = count_ff - CNT_W'(2);
            end else if (prev_free) begin
               cmd_in.lo_idx  = pc - CNT_W'(1);
               cmd_in.data_lo = '{alloc: 1'b0, owner: '0, len: prev_ff.len + sel_ff.len,
                                  start: prev_ff.start};
               cmd_in.shift   = SH_LEFT1;
               cmd_in.base    = pc;
               count_in       = count_ff - CNT_W'(1);
            end else if (next_free) begin
               cmd_in.lo_idx  = pc;
               cmd_in.data_lo = '{alloc: 1'b0, owner: '0, len: sel_ff.len + next_ff.len,
                                  start: sel_ff.start};
               cmd_in.shift   = SH_LEFT1;
               cmd_in.base    = pc + CNT_W'(1);
               count_in       = count_ff - CNT_W'(1);
            end else begin
               cmd_in.lo_idx  = pc;
               cmd_in.data_lo = '{alloc: 1'b0, owner: '0, len: sel_ff.len,
                                  start: sel_ff.start};
            end
         end else if (prev_free) begin
            // leading part goes into the free segment before it
            cmd_in.we_lo   = 1'b1;
            cmd_in.we_hi   = 1'b1;
            cmd_in.lo_idx  = pc - CNT_W'(1);
            cmd_in.data_lo = '{alloc: 1'b0, owner: '0, len: prev_ff.len + amount_ff,
                               start: prev_ff.start};
            cmd_in.data_hi = '{alloc: 1'b1, owner: owner_ff, len: rest_len,
                               start: rest_start};
         end else if (table_full) begin
            status_in = ST_TABLE_FULL;
         end else begin
            cmd_in.we_lo   = 1'b1;
            cmd_in.we_hi   = 1'b1;
            cmd_in.lo_idx  = pc;
            cmd_in.data_lo = '{alloc: 1'b0, owner: '0, len: amount_ff, start: sel_ff.start};
            cmd_in.data_hi = '{alloc: 1'b1, owner: owner_ff, len: rest_len,
                               start: rest_start};
            cmd_in.shift   = SH_RIGHT;
            cmd_in.base    = pc + CNT_W'(2);
            count_in       = count_ff + CNT_W'(1);
         end
      end
      if (status_in != ST_OK) begin
         start_in = '0;
      end
      cmd_in.apply = 1'b1;
   end

   // sequencer with registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= CNT_W'(1);
         rsp_valid_ff <= 1'b0;
         cmd_ff       <= '0;
         first_ff     <= '0;
         any_ff       <= 1'b0;
      end else begin
         // result register: loaded by the decide step, emptied by a transfer
         if (state_ff == S_DECIDE && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               // clear the cell update that the decide step loaded
               cmd_ff.apply <= 1'b0;
               if (req_tvalid) begin
                  op_ff     <= req_tuser;
                  owner_ff  <= req_tdata[7:0];
                  amount_ff <= req_tdata[17:8];
                  state_ff  <= S_FIND;
               end
            end
            S_FIND: begin
               first_ff <= first_c;
               any_ff   <= |match;
               pos_ff   <= pos_c;
               state_ff <= S_GATHER;
            end
            S_GATHER: begin
               sel_ff   <= sel_c;
               prev_ff  <= prev_c;
               next_ff  <= next_c;
               state_ff <= S_DECIDE;
            end
            S_DECIDE: begin
               if (out_free) begin
                  cmd_ff        <= cmd_in;
                  count_ff      <= count_in;
                  rsp_status_ff <= status_in;
                  rsp_start_ff  <= start_in;
                  rsp_count_ff  <= count_in;
                  state_ff      <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'd0, rsp_count_ff, rsp_start_ff, rsp_status_ff};

`ifndef ASSERT_OFF
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      (count_ff >= CNT_W'(1)) && (count_ff <= CNT_W'(MAX_SEGMENTS)))
      else $error("segment count out of range");

   a_first_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0(first_ff) && (any_ff == (first_ff != '0)))
      else $error("first-fit select not one-hot");

   a_apply_pulse: assert property (@(posedge clock) disable iff (reset)
      cmd_ff.apply |=> !cmd_ff.apply)
      else $error("cell update held more than one cycle");

   a_apply_after_decide: assert property (@(posedge clock) disable iff (reset)
      cmd_ff.apply |-> (state_ff == S_IDLE) && rsp_valid_ff)
      else $error("cell update without a result");
`endif

endmodule

// ===== verif/first_fit_partition_allocator_top_test.sv =====
// self-checking testbench for the first-fit partition allocator top level
module first_fit_partition_allocator_top_test;
   import ffpa_pkg::*;

   // allocator request and response as seen on the streams
   typedef struct {
      logic       op;
      logic [7:0] owner;
      logic [9:0] amount;
   } alloc_req_type;

   typedef struct {
      logic [2:0] status;
      logic [8:0] seg_start;
      logic [6:0] seg_count;
   } alloc_rsp_type;

   // one directed row; has_rsp marks rows whose answer is typed in
   typedef struct {
      alloc_req_type req;
      logic          has_rsp;
      alloc_rsp_type rsp;
   } directed_row_type;

   // predictor copy of one segment
   typedef struct {
      int unsigned seg_base;
      int unsigned seg_len;
      int unsigned seg_owner;
      bit          taken;
   } segment_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;
   logic        req_tuser = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;

   segment_type   seg_map[MAX_SEGMENTS];
   int unsigned   seg_total;
   alloc_rsp_type pending_rsp[$];
   int            error_count = 0;
   int            rsp_seen = 0;

   first_fit_partition_allocator_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #2 clock = ~clock;

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch at response %0d: %s got %0d expected %0d", rsp_seen, what, got, want);
      error_count++;
   endtask

   // table maintenance for the predictor
   function automatic void map_clear();
      foreach (seg_map[k]) seg_map[k] = '{0, 0, 0, 1'b0};
      seg_map[0].seg_len = TOTAL_UNITS;
      seg_total = 1;
   endfunction

   function automatic void map_insert(input int unsigned pos);
      for (int unsigned k = seg_total; k > pos; k--) seg_map[k] = seg_map[k-1];
      seg_total++;
   endfunction

   function automatic void map_remove(input int unsigned pos);
      for (int unsigned k = pos; k + 1 < seg_total; k++) seg_map[k] = seg_map[k+1];
      seg_total--;
      seg_map[seg_total] = '{0, 0, 0, 1'b0};
   endfunction

   function automatic logic [2:0] place_first_fit(input int unsigned who, input int unsigned amt,
                                                 output int unsigned at);
      at = 0;
      if (amt == 0) return ST_NO_SPACE;
      for (int unsigned i = 0; i < seg_total; i++) begin
         if (seg_map[i].taken || seg_map[i].seg_len < amt) continue;
         if (seg_map[i].seg_len != amt) begin
            if (seg_total >= MAX_SEGMENTS) return ST_TABLE_FULL;
            map_insert(i + 1);
            seg_map[i+1] = '{seg_map[i].seg_base + amt, seg_map[i].seg_len - amt, 0, 1'b0};
            seg_map[i].seg_len = amt;
         end
         seg_map[i].seg_owner = who;
         seg_map[i].taken = 1'b1;
         at = seg_map[i].seg_base;
         return ST_OK;
      end
      return ST_NO_SPACE;
   endfunction

   function automatic logic [2:0] free_owned(input int unsigned who, input int unsigned amt,
                                            output int unsigned at);
      int unsigned i;
      bit          left_free;
      at = 0;
      for (i = 0; i < seg_total; i++)
         if (seg_map[i].taken && seg_map[i].seg_owner == who) break;
      if (i >= seg_total) return ST_NO_OWNER;
      left_free = (i > 0) && !seg_map[i-1].taken;
      if (amt == 0 || amt > seg_map[i].seg_len) return ST_EXCEEDS;
      at = seg_map[i].seg_base;
      if (amt == seg_map[i].seg_len) begin
         seg_map[i].taken = 1'b0;
         seg_map[i].seg_owner = 0;
         if (i + 1 < seg_total && !seg_map[i+1].taken) begin
            seg_map[i].seg_len += seg_map[i+1].seg_len;
            map_remove(i + 1);
         end
         if (left_free) begin
            seg_map[i-1].seg_len += seg_map[i].seg_len;
            map_remove(i);
         end
         return ST_OK;
      end
      if (left_free) begin
         seg_map[i-1].seg_len += amt;
         seg_map[i].seg_base += amt;
         seg_map[i].seg_len -= amt;
         return ST_OK;
      end
      if (seg_total >= MAX_SEGMENTS) return ST_TABLE_FULL;
      map_insert(i + 1);
      seg_map[i+1] = '{seg_map[i].seg_base + amt, seg_map[i].seg_len - amt, who, 1'b1};
      seg_map[i].seg_len = amt;
      seg_map[i].seg_owner = 0;
      seg_map[i].taken = 1'b0;
      return ST_OK;
   endfunction

   function automatic alloc_rsp_type predict_step(input alloc_req_type r);
      alloc_rsp_type p;
      int unsigned   at;
      if (r.op == OP_ALLOC) p.status = place_first_fit(r.owner, r.amount, at);
      else p.status = free_owned(r.owner, r.amount, at);
      if (p.status != ST_OK) at = 0;
      p.seg_start = at[8:0];
      p.seg_count = seg_total[6:0];
      return p;
   endfunction

   // occasional gap: mostly none, otherwise usually short, sometimes long
   function automatic int unsigned pick_gap();
      int unsigned r = $urandom_range(99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(3, 1);
      return $urandom_range(40, 8);
   endfunction

   // send one transfer; checks the typed-in answer when there is one
   task automatic send_req(input alloc_req_type r, input logic has_rsp, input alloc_rsp_type want);
      alloc_rsp_type p;
      int unsigned   g;
      g = pick_gap();
      // drop valid only when a gap comes before this transfer; otherwise it follows the last one directly
      if (g != 0) begin
         req_tvalid <= 1'b0;
         repeat (g) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= r.op;
      req_tdata  <= {6'b0, r.amount, r.owner};
      do @(posedge clock); while (!req_tready);
      p = predict_step(r);
      if (has_rsp) begin
         if (p.status != want.status)
            report_mismatch("directed status vs predictor", p.status, want.status);
         if (p.seg_start != want.seg_start)
            report_mismatch("directed seg_start vs predictor", p.seg_start, want.seg_start);
         if (p.seg_count != want.seg_count)
            report_mismatch("directed seg_count vs predictor", p.seg_count, want.seg_count);
      end
      pending_rsp.push_back(p);
   endtask

   // response side: random stalls, compare each transfer with the oldest prediction
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            alloc_rsp_type want;
            rsp_seen++;
            if (pending_rsp.size() == 0) begin
               $display("unexpected response transfer %0d", rsp_seen);
               error_count++;
            end else begin
               want = pending_rsp.pop_front();
               if (rsp_tdata[2:0] != want.status)
                  report_mismatch("status", rsp_tdata[2:0], want.status);
               if (rsp_tdata[11:3] != want.seg_start)
                  report_mismatch("seg_start", rsp_tdata[11:3], want.seg_start);
               if (rsp_tdata[18:12] != want.seg_count)
                  report_mismatch("seg_count", rsp_tdata[18:12], want.seg_count);
            end
         end
         rsp_tready <= (pick_gap() == 0) || ($urandom_range(3) == 0);
      end
   end

   // owners used by the random part; a small pool keeps releases finding holders
   function automatic logic [7:0] pick_owner();
      if ($urandom_range(9) == 0) return 8'($urandom());
      return 8'($urandom_range(7)) ^ ($urandom_range(1) ? 8'hF8 : 8'h00);
   endfunction

   function automatic logic [9:0] pick_amount();
      int unsigned r = $urandom_range(99);
      if (r < 70) return 10'($urandom_range(16, 1));
      if (r < 90) return 10'($urandom_range(64, 1));
      if (r < 97) return 10'($urandom_range(512, 1));
      return 10'($urandom());
   endfunction

   directed_row_type directed[] = '{
      // zero allocate after reset: no space, one segment
      '{'{OP_ALLOC,   8'h00, 10'd0},   1'b1, '{ST_NO_SPACE, 9'd0, 7'd1}},
      // release with nothing held
      '{'{OP_RELEASE, 8'h00, 10'd0},   1'b1, '{ST_NO_OWNER, 9'd0, 7'd1}},
      '{'{OP_ALLOC,   8'hFF, 10'd513}, 1'b1, '{ST_NO_SPACE, 9'd0, 7'd1}},
      '{'{OP_ALLOC,   8'hFF, 10'd1023},1'b1, '{ST_NO_SPACE, 9'd0, 7'd1}},
      // exact fit of the whole memory, then full release
      '{'{OP_ALLOC,   8'hFF, 10'd512}, 1'b1, '{ST_OK, 9'd0, 7'd1}},
      '{'{OP_ALLOC,   8'h01, 10'd1},   1'b1, '{ST_NO_SPACE, 9'd0, 7'd1}},
      '{'{OP_RELEASE, 8'hFF, 10'd0},   1'b1, '{ST_EXCEEDS, 9'd0, 7'd1}},
      '{'{OP_RELEASE, 8'hFF, 10'd513}, 1'b1, '{ST_EXCEEDS, 9'd0, 7'd1}},
      '{'{OP_RELEASE, 8'hFF, 10'd512}, 1'b1, '{ST_OK, 9'd0, 7'd1}},
      // splits and partial releases, checked by the predictor
      '{'{OP_ALLOC,   8'h00, 10'd10},  1'b0, '{0, 0, 0}},
      '{'{OP_ALLOC,   8'h55, 10'd20},  1'b0, '{0, 0, 0}},
      '{'{OP_ALLOC,   8'hAA, 10'd30},  1'b0, '{0, 0, 0}},
      '{'{OP_RELEASE, 8'h00, 10'd4},   1'b0, '{0, 0, 0}},
      '{'{OP_RELEASE, 8'h55, 10'd5},   1'b0, '{0, 0, 0}},
      '{'{OP_RELEASE, 8'h00, 10'd6},   1'b0, '{0, 0, 0}},
      '{'{OP_RELEASE, 8'hAA, 10'd30},  1'b0, '{0, 0, 0}},
      '{'{OP_RELEASE, 8'h55, 10'd15},  1'b0, '{0, 0, 0}},
      '{'{OP_ALLOC,   8'h12, 10'd300}, 1'b0, '{0, 0, 0}},
      '{'{OP_ALLOC,   8'h34, 10'd212}, 1'b0, '{0, 0, 0}},
      '{'{OP_RELEASE, 8'h12, 10'd300}, 1'b0, '{0, 0, 0}},
      '{'{OP_RELEASE, 8'h34, 10'd212}, 1'b0, '{0, 0, 0}}
   };

   initial begin
      alloc_req_type r;
      alloc_rsp_type unused;
      map_clear();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      foreach (directed[k]) send_req(directed[k].req, directed[k].has_rsp, directed[k].rsp);
      // fill the table with single units to reach table full, then free alternate ones
      for (int k = 0; k < 66; k++) begin
         r = '{OP_ALLOC, 8'(k), 10'd1};
         send_req(r, 1'b0, unused);
      end
      for (int k = 0; k < 66; k += 2) begin
         r = '{OP_RELEASE, 8'(k), 10'd1};
         send_req(r, 1'b0, unused);
      end
      for (int k = 0; k < 4; k++) begin
         r = '{OP_ALLOC, 8'hC0, 10'd2};
         send_req(r, 1'b0, unused);
      end
      for (int k = 0; k < 66; k++) begin
         r = '{OP_RELEASE, 8'(k), 10'd1};
         send_req(r, 1'b0, unused);
      end
      r = '{OP_RELEASE, 8'hC0, 10'd2};
      repeat (4) send_req(r, 1'b0, unused);
      // random mix, allocations slightly favored
      for (int k = 0; k < 450; k++) begin
         r.op = ($urandom_range(99) < 55) ? OP_ALLOC : OP_RELEASE;
         r.owner = pick_owner();
         r.amount = pick_amount();
         send_req(r, 1'b0, unused);
      end
      req_tvalid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (error_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   // watchdog
   initial begin
      #2000000;
      $display("FAIL");
      $finish;
   end

endmodule

// ===== files.f =====
sv/ffpa_pkg.sv
sv/ffpa_cell.sv
sv/first_fit_partition_allocator_top.sv
verif/first_fit_partition_allocator_top_test.sv
